// File: src/sprite_box_circle_collision_macros.svh
// ----------------------------------------------------------------------------
// Sprite collision tester assertion macros
// Shared property wrappers; clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SPRITE_BOX_CIRCLE_COLLISION_MACROS_SVH
`define SPRITE_BOX_CIRCLE_COLLISION_MACROS_SVH

// Same-cycle implication.
`define SBCC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SBCC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/sbcc_pkg.sv
// ----------------------------------------------------------------------------
// Sprite collision tester package
// Codes, widths, the queued job record and the back-end state type.
// ----------------------------------------------------------------------------
package sbcc_pkg;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEST = 1'b1;

    // Shape codes
    localparam logic [1:0] SHAPE_RECT  = 2'd0;
    localparam logic [1:0] SHAPE_ROUND = 2'd1;

    // Outcome codes
    localparam logic [1:0] OUT_MISS  = 2'd0;
    localparam logic [1:0] OUT_HIT   = 2'd1;
    localparam logic [1:0] OUT_UNSUP = 2'd2;

    // Widths
    localparam int FIELD_W  = 16;              // raw input field
    localparam int DMAG_W   = 17;              // |centre difference| in Q11.4
    localparam int CTR_SH   = 9;               // Q11.4 -> 2^-13 units
    localparam int DIST_W   = DMAG_W + CTR_SH; // |centre difference| in 2^-13 units
    localparam int MUL_W    = 31;              // multiplier operand
    localparam int PROD_W   = 2 * MUL_W;       // multiplier product
    localparam int STEP_W   = 3;

    // Queue between front and back
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_UNSUP,
        OP_BOX_BOX,
        OP_BOX_CIRCLE
    } t_op;

    // For box/circle, side a is the box and side b the circle.
    typedef struct packed {
        t_op                 op;
        logic [FIELD_W-1:0]  a_w;
        logic [FIELD_W-1:0]  a_sx;
        logic [FIELD_W-1:0]  a_h;
        logic [FIELD_W-1:0]  a_sy;
        logic [FIELD_W-1:0]  b_w;
        logic [FIELD_W-1:0]  b_sx;
        logic [FIELD_W-1:0]  b_h;
        logic [FIELD_W-1:0]  b_sy;
        logic [DMAG_W-1:0]   dxm;
        logic [DMAG_W-1:0]   dym;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } t_state;

endpackage

// File: src/sprite_box_circle_collision.sv
// ----------------------------------------------------------------------------
// Sprite box/circle collision tester
// Stores a reference sprite and tests later sprites against it.
// ----------------------------------------------------------------------------
// A load request (command 0) stores the sprite as the reference and
// produces no result. A test request (command 1) is classified by the
// front end against the current reference and queued; the back end then runs
// it on one shared 31x31 multiplier, one product per cycle, and returns one
// outcome: 0 no overlap, 1 overlap, 2 unsupported pair. Box against box is an
// inclusive overlap test on both axes; box against circle clamps the circle
// centre into the box and compares squared distance against radius squared.
// A circle counts only with equal raw width and height and equal raw scales;
// circle/circle and shape codes 2 and 3 are unsupported. The back end takes a
// job from the queue, then settles an unsupported pair with no product, runs
// four extent products for box/box and six for box/circle (three extents,
// three squares), and takes the next job once the outcome is in the output register.
// Loads and up to two queued tests are taken while the back end is busy or a
// finished outcome waits in the output register; a load updates the reference
// only for tests accepted after it.
// ----------------------------------------------------------------------------
module sprite_box_circle_collision import sbcc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_command,
    input  logic [1:0]          i_shape,
    input  logic [FIELD_W-1:0]  i_pos_x,
    input  logic [FIELD_W-1:0]  i_pos_y,
    input  logic [FIELD_W-1:0]  i_offset_x,
    input  logic [FIELD_W-1:0]  i_offset_y,
    input  logic [FIELD_W-1:0]  i_box_width,
    input  logic [FIELD_W-1:0]  i_box_height,
    input  logic [FIELD_W-1:0]  i_scale_x,
    input  logic [FIELD_W-1:0]  i_scale_y,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_outcome
);

    // front -> queue
    logic push;
    t_job push_job;
    // queue -> back
    logic q_full, q_empty, pop;
    t_job head_job;

    // Classify and latch everything a test needs; hold off when queue is full.
    sbcc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_command    (i_command),
        .i_shape      (i_shape),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_offset_x   (i_offset_x),
        .i_offset_y   (i_offset_y),
        .i_box_width  (i_box_width),
        .i_box_height (i_box_height),
        .i_scale_x    (i_scale_x),
        .i_scale_y    (i_scale_y),
        .i_full       (q_full),
        .o_ready      (o_in_ready),
        .o_push       (push),
        .o_job        (push_job)
    );

    // Decouple the two sides.
    sbcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    // Sequence the products and compares; hold the outcome until taken.
    sbcc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (q_empty),
        .i_job     (head_job),
        .o_pop     (pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_outcome (o_outcome)
    );

endmodule

// File: src/sbcc_front.sv
// ----------------------------------------------------------------------------
// Sprite collision tester front end
// Holds the reference sprite, classifies test requests and queues jobs.
// ----------------------------------------------------------------------------
module sbcc_front import sbcc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_command,
    input  logic [1:0]          i_shape,
    input  logic [FIELD_W-1:0]  i_pos_x,
    input  logic [FIELD_W-1:0]  i_pos_y,
    input  logic [FIELD_W-1:0]  i_offset_x,
    input  logic [FIELD_W-1:0]  i_offset_y,
    input  logic [FIELD_W-1:0]  i_box_width,
    input  logic [FIELD_W-1:0]  i_box_height,
    input  logic [FIELD_W-1:0]  i_scale_x,
    input  logic [FIELD_W-1:0]  i_scale_y,
    input  logic                i_full,
    output logic                o_ready,
    output logic                o_push,
    output t_job                o_job
);

    logic [1:0]         r_ref_shape;
    logic [FIELD_W-1:0] r_ref_pos_x, r_ref_pos_y, r_ref_offset_x, r_ref_offset_y;
    logic [FIELD_W-1:0] r_ref_width, r_ref_height, r_ref_scale_x, r_ref_scale_y;

    logic               accept;
    logic               in_circle, ref_circle;
    logic [DMAG_W-1:0]  dxm, dym;

    function automatic logic [FIELD_W-1:0] f_mag(input logic [FIELD_W-1:0] v);
        return v[FIELD_W-1] ? (~v + 1'b1) : v;
    endfunction

    // |(p_in + o_in) - (p_ref + o_ref)| in Q11.4
    function automatic logic [DMAG_W-1:0] f_dist(
        input logic [FIELD_W-1:0] p_in,
        input logic [FIELD_W-1:0] o_in,
        input logic [FIELD_W-1:0] p_ref,
        input logic [FIELD_W-1:0] o_ref
    );
        logic [DMAG_W-1:0] s_in, s_ref;
        logic [DMAG_W:0]   d;
        s_in  = {p_in[FIELD_W-1], p_in} + {o_in[FIELD_W-1], o_in};
        s_ref = {p_ref[FIELD_W-1], p_ref} + {o_ref[FIELD_W-1], o_ref};
        d     = {s_in[DMAG_W-1], s_in} - {s_ref[DMAG_W-1], s_ref};
        if (d[DMAG_W]) begin
            d = ~d + 1'b1;
        end
        return d[DMAG_W-1:0];
    endfunction

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && (i_command == CMD_TEST);

    // A circle needs equal raw width/height and equal raw scales.
    assign in_circle  = (i_box_width == i_box_height) && (i_scale_x == i_scale_y);
    assign ref_circle = (r_ref_width == r_ref_height) && (r_ref_scale_x == r_ref_scale_y);

    assign dxm = f_dist(i_pos_x, i_offset_x, r_ref_pos_x, r_ref_offset_x);
    assign dym = f_dist(i_pos_y, i_offset_y, r_ref_pos_y, r_ref_offset_y);

    always_comb begin
        o_job.op   = OP_UNSUP;
        o_job.dxm  = dxm;
        o_job.dym  = dym;
        // default: reference on side a
        o_job.a_w  = f_mag(r_ref_width);
        o_job.a_sx = f_mag(r_ref_scale_x);
        o_job.a_h  = f_mag(r_ref_height);
        o_job.a_sy = f_mag(r_ref_scale_y);
        o_job.b_w  = f_mag(i_box_width);
        o_job.b_sx = f_mag(i_scale_x);
        o_job.b_h  = f_mag(i_box_height);
        o_job.b_sy = f_mag(i_scale_y);
        if (r_ref_shape == SHAPE_RECT && i_shape == SHAPE_RECT) begin
            o_job.op = OP_BOX_BOX;
        end else if (r_ref_shape == SHAPE_RECT && i_shape == SHAPE_ROUND) begin
            o_job.op = in_circle ? OP_BOX_CIRCLE : OP_UNSUP;
        end else if (r_ref_shape == SHAPE_ROUND && i_shape == SHAPE_RECT) begin
            // swap: incoming box on side a, reference circle on side b
            o_job.op   = ref_circle ? OP_BOX_CIRCLE : OP_UNSUP;
            o_job.a_w  = f_mag(i_box_width);
            o_job.a_sx = f_mag(i_scale_x);
            o_job.a_h  = f_mag(i_box_height);
            o_job.a_sy = f_mag(i_scale_y);
            o_job.b_w  = f_mag(r_ref_width);
            o_job.b_sx = f_mag(r_ref_scale_x);
            o_job.b_h  = f_mag(r_ref_height);
            o_job.b_sy = f_mag(r_ref_scale_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_shape    <= SHAPE_RECT;
            r_ref_pos_x    <= '0;
            r_ref_pos_y    <= '0;
            r_ref_offset_x <= '0;
            r_ref_offset_y <= '0;
            r_ref_width    <= '0;
            r_ref_height   <= '0;
            r_ref_scale_x  <= '0;
            r_ref_scale_y  <= '0;
        end else if (accept && i_command == CMD_LOAD) begin
            r_ref_shape    <= i_shape;
            r_ref_pos_x    <= i_pos_x;
            r_ref_pos_y    <= i_pos_y;
            r_ref_offset_x <= i_offset_x;
            r_ref_offset_y <= i_offset_y;
            r_ref_width    <= i_box_width;
            r_ref_height   <= i_box_height;
            r_ref_scale_x  <= i_scale_x;
            r_ref_scale_y  <= i_scale_y;
        end
    end

endmodule

// File: src/sbcc_queue.sv
// ----------------------------------------------------------------------------
// Sprite collision tester job queue
// Small FIFO of classified jobs between front and back end.
// ----------------------------------------------------------------------------
module sbcc_queue import sbcc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_job  i_job,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_job  o_job
);

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr, r_rptr, n_wptr, n_rptr;
    logic [Q_CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

// File: src/sbcc_back.sv
// ----------------------------------------------------------------------------
// Sprite collision tester back end
// Runs one job at a time on a shared multiplier and holds the result.
// ----------------------------------------------------------------------------
module sbcc_back import sbcc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_outcome
);

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    t_job                r_job, n_job;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [PROD_W-1:0]   r_acc, n_acc;
    logic [PROD_W-1:0]   r_rsq, n_rsq;
    logic [DIST_W-1:0]   r_gx, n_gx, r_gy, n_gy;
    logic                r_hit, n_hit;
    logic [1:0]          r_res, n_res;
    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_outcome, n_outcome;

    logic [MUL_W-1:0]    mul_a, mul_b;
    logic [DIST_W-1:0]   dx_d, dy_d;
    logic [MUL_W:0]      ext_sum;
    logic [PROD_W-1:0]   sq_sum;
    logic                out_free, done;
    logic [1:0]          res;

    function automatic logic [DIST_W-1:0] f_gap(
        input logic [DIST_W-1:0] d,
        input logic [MUL_W-1:0]  h
    );
        logic [DIST_W-1:0] g;
        g = '0;
        if (MUL_W'(d) > h) begin
            g = d - h[DIST_W-1:0];
        end
        return g;
    endfunction

    assign dx_d     = {r_job.dxm, {CTR_SH{1'b0}}};
    assign dy_d     = {r_job.dym, {CTR_SH{1'b0}}};
    assign ext_sum  = {1'b0, r_acc[MUL_W-1:0]} + {1'b0, r_prod[MUL_W-1:0]};
    assign sq_sum   = r_acc + r_prod;
    assign out_free = !r_out_valid || i_ready;
    assign n_prod   = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_job       = r_job;
        n_acc       = r_acc;
        n_rsq       = r_rsq;
        n_gx        = r_gx;
        n_gy        = r_gy;
        n_hit       = r_hit;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_ready;
        n_outcome   = r_outcome;
        o_pop       = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        done        = 1'b0;
        res         = OUT_UNSUP;

        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_job   = i_job;
                    n_step  = '0;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_step = r_step + 1'b1;
                case (r_job.op)
                    OP_BOX_BOX: begin
                        // half extents: a.x, b.x, a.y, b.y
                        case (r_step)
                            3'd0: begin
                                mul_a = MUL_W'(r_job.a_w);
                                mul_b = MUL_W'(r_job.a_sx);
                            end
                            3'd1: begin
                                mul_a = MUL_W'(r_job.b_w);
                                mul_b = MUL_W'(r_job.b_sx);
                                n_acc = r_prod;
                            end
                            3'd2: begin
                                mul_a = MUL_W'(r_job.a_h);
                                mul_b = MUL_W'(r_job.a_sy);
                                n_hit = ((MUL_W + 1)'(dx_d) <= ext_sum);
                            end
                            3'd3: begin
                                mul_a = MUL_W'(r_job.b_h);
                                mul_b = MUL_W'(r_job.b_sy);
                                n_acc = r_prod;
                            end
                            default: begin
                                done = 1'b1;
                                res  = (r_hit && ((MUL_W + 1)'(dy_d) <= ext_sum)) ?
                                       OUT_HIT : OUT_MISS;
                            end
                        endcase
                    end
                    OP_BOX_CIRCLE: begin
                        // box half extents, radius, radius squared, gaps squared
                        case (r_step)
                            3'd0: begin
                                mul_a = MUL_W'(r_job.a_w);
                                mul_b = MUL_W'(r_job.a_sx);
                            end
                            3'd1: begin
                                mul_a = MUL_W'(r_job.a_h);
                                mul_b = MUL_W'(r_job.a_sy);
                                n_gx  = f_gap(dx_d, r_prod[MUL_W-1:0]);
                            end
                            3'd2: begin
                                mul_a = MUL_W'(r_job.b_w);
                                mul_b = MUL_W'(r_job.b_sx);
                                n_gy  = f_gap(dy_d, r_prod[MUL_W-1:0]);
                            end
                            3'd3: begin
                                mul_a = r_prod[MUL_W-1:0];
                                mul_b = r_prod[MUL_W-1:0];
                            end
                            3'd4: begin
                                mul_a = MUL_W'(r_gx);
                                mul_b = MUL_W'(r_gx);
                                n_rsq = r_prod;
                            end
                            3'd5: begin
                                mul_a = MUL_W'(r_gy);
                                mul_b = MUL_W'(r_gy);
                                n_acc = r_prod;
                            end
                            default: begin
                                done = 1'b1;
                                res  = (sq_sum < r_rsq) ? OUT_HIT : OUT_MISS;
                            end
                        endcase
                    end
                    default: begin
                        done = 1'b1;
                        res  = OUT_UNSUP;
                    end
                endcase
                if (done) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_outcome   = res;
                        n_state     = ST_IDLE;
                    end else begin
                        n_res   = res;
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_outcome   = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job     <= n_job;
        r_prod    <= n_prod;
        r_acc     <= n_acc;
        r_rsq     <= n_rsq;
        r_gx      <= n_gx;
        r_gy      <= n_gy;
        r_hit     <= n_hit;
        r_res     <= n_res;
        r_outcome <= n_outcome;
    end

    assign o_valid   = r_out_valid;
    assign o_outcome = r_outcome;

endmodule

// File: src/sbcc_checker.sv
// ----------------------------------------------------------------------------
// Sprite collision tester port checker
// Watches the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
`include "sprite_box_circle_collision_macros.svh"

module sbcc_checker import sbcc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_ready,
    input  logic                i_command,
    input  logic [1:0]          i_shape,
    input  logic [FIELD_W-1:0]  i_pos_x,
    input  logic [FIELD_W-1:0]  i_pos_y,
    input  logic [FIELD_W-1:0]  i_offset_x,
    input  logic [FIELD_W-1:0]  i_offset_y,
    input  logic [FIELD_W-1:0]  i_box_width,
    input  logic [FIELD_W-1:0]  i_box_height,
    input  logic [FIELD_W-1:0]  i_scale_x,
    input  logic [FIELD_W-1:0]  i_scale_y,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  logic [1:0]          o_outcome
);

    // queue entries, one running job, one output register
    localparam int MAX_PENDING = Q_DEPTH + 2;
    localparam int PEND_W      = $clog2(MAX_PENDING + 2);

    logic [PEND_W-1:0] r_pending, n_pending;
    logic              test_in, result_out;

    assign test_in    = i_in_valid && o_in_ready && (i_command == CMD_TEST);
    assign result_out = o_out_valid && i_out_ready;

    always_comb begin
        n_pending = r_pending;
        if (test_in && !result_out) begin
            n_pending = r_pending + 1'b1;
        end else if (result_out && !test_in) begin
            n_pending = r_pending - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    `SBCC_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_outcome), "outcome dropped or changed while stalled")
    `SBCC_ASSERT_IMP(a_no_orphan, o_out_valid, r_pending != '0, "result without an outstanding test")
    `SBCC_ASSERT_IMP(a_capacity, 1'b1, r_pending <= PEND_W'(MAX_PENDING), "more tests in flight than storage")
    `SBCC_ASSERT_IMP(a_idle_ready, r_pending == '0, o_in_ready, "requests refused while empty")
    `SBCC_ASSERT_IMP(a_code, o_out_valid, o_outcome == OUT_MISS || o_outcome == OUT_HIT || o_outcome == OUT_UNSUP, "undefined outcome code")

endmodule

bind sprite_box_circle_collision sbcc_checker u_sbcc_checker (.*);

// File: bench/sbcc_outcome_checker.sv
// ----------------------------------------------------------------------------
// Sprite collision outcome checker
// Watches both channels of the collision tester. It keeps its own copy of
// the reference sprite, works out the outcome of every accepted test request
// and compares each returned outcome with the oldest one still waiting.
// ----------------------------------------------------------------------------
module sbcc_outcome_checker import sbcc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic                i_command,
    input  logic [1:0]          i_shape,
    input  logic [FIELD_W-1:0]  i_pos_x,
    input  logic [FIELD_W-1:0]  i_pos_y,
    input  logic [FIELD_W-1:0]  i_offset_x,
    input  logic [FIELD_W-1:0]  i_offset_y,
    input  logic [FIELD_W-1:0]  i_box_width,
    input  logic [FIELD_W-1:0]  i_box_height,
    input  logic [FIELD_W-1:0]  i_scale_x,
    input  logic [FIELD_W-1:0]  i_scale_y,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [1:0]          i_outcome,
    output int                  o_errors,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]                 shape;
        logic signed [FIELD_W-1:0]  px, py, ox, oy, w, h, sx, sy;
    } t_sprite;

    t_sprite    ref_sprite;
    logic [1:0] pending_outcomes[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    // centre of the collision shape in 2^-13 pixel units
    function automatic longint centre_at(logic signed [FIELD_W-1:0] p,
                                         logic signed [FIELD_W-1:0] o);
        return (longint'(p) + longint'(o)) * 512;
    endfunction

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // |size| * |scale| is the half extent in 2^-13 pixel units
    function automatic longint half_extent(logic signed [FIELD_W-1:0] size,
                                           logic signed [FIELD_W-1:0] scale);
        return magnitude(longint'(size)) * magnitude(longint'(scale));
    endfunction

    function automatic bit spans_meet(longint ca, longint ha, longint cb, longint hb);
        longint lo_a, lo_b, hi_a, hi_b;
        lo_a = ca - ha;
        lo_b = cb - hb;
        hi_a = lo_a + 2 * ha;
        hi_b = lo_b + 2 * hb;
        return (lo_a >= lo_b && lo_a <= hi_b) || (lo_b >= lo_a && lo_b <= hi_a);
    endfunction

    function automatic bit boxes_meet(t_sprite a, t_sprite b);
        return spans_meet(centre_at(a.px, a.ox), half_extent(a.w, a.sx),
                          centre_at(b.px, b.ox), half_extent(b.w, b.sx)) &&
               spans_meet(centre_at(a.py, a.oy), half_extent(a.h, a.sy),
                          centre_at(b.py, b.oy), half_extent(b.h, b.sy));
    endfunction

    // distance from d to the nearest point of [-half, half]
    function automatic longint clamp_gap(longint d, longint half);
        longint c;
        c = d;
        if (c < -half) c = -half;
        if (c > half) c = half;
        return magnitude(c - d);
    endfunction

    function automatic bit box_meets_circle(t_sprite box, t_sprite cir);
        longint gx, gy, r;
        gx = clamp_gap(centre_at(cir.px, cir.ox) - centre_at(box.px, box.ox),
                       half_extent(box.w, box.sx));
        gy = clamp_gap(centre_at(cir.py, cir.oy) - centre_at(box.py, box.oy),
                       half_extent(box.h, box.sy));
        r  = half_extent(cir.w, cir.sx);
        return gx * gx + gy * gy < r * r;
    endfunction

    function automatic bit is_round(t_sprite s);
        return s.w == s.h && s.sx == s.sy;
    endfunction

    function automatic logic [1:0] predict_outcome(t_sprite a, t_sprite b);
        if (a.shape == SHAPE_RECT && b.shape == SHAPE_RECT)
            return boxes_meet(a, b) ? OUT_HIT : OUT_MISS;
        if (a.shape == SHAPE_RECT && b.shape == SHAPE_ROUND)
            return !is_round(b) ? OUT_UNSUP : box_meets_circle(a, b) ? OUT_HIT : OUT_MISS;
        if (a.shape == SHAPE_ROUND && b.shape == SHAPE_RECT)
            return !is_round(a) ? OUT_UNSUP : box_meets_circle(b, a) ? OUT_HIT : OUT_MISS;
        return OUT_UNSUP;
    endfunction

    always @(posedge i_clk) begin
        t_sprite    incoming;
        logic [1:0] want;
        if (!i_rst_n) begin
            ref_sprite = '{default: '0};
            pending_outcomes.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_outcomes.size() == 0) begin
                    $display("%0t: unexpected outcome, expected none, actual %0d",
                             $time, i_outcome);
                    o_errors = o_errors + 1;
                end else begin
                    want = pending_outcomes.pop_front();
                    if (want !== i_outcome) begin
                        $display("%0t: outcome mismatch, expected %0d, actual %0d",
                                 $time, want, i_outcome);
                        o_errors = o_errors + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                incoming.shape = i_shape;
                incoming.px    = i_pos_x;
                incoming.py    = i_pos_y;
                incoming.ox    = i_offset_x;
                incoming.oy    = i_offset_y;
                incoming.w     = i_box_width;
                incoming.h     = i_box_height;
                incoming.sx    = i_scale_x;
                incoming.sy    = i_scale_y;
                if (i_command == CMD_LOAD)
                    ref_sprite = incoming;
                else
                    pending_outcomes.push_back(predict_outcome(ref_sprite, incoming));
            end
        end
        o_pending = pending_outcomes.size();
    end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Sprite collision tester testbench
// Drives load and test requests into the collision tester, first a directed
// set around touching edges, circle rules and field extremes, then random
// sprites in phases with different idle and stall rates. A checker beside the
// block predicts every outcome; this module only makes stimulus and reports.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sbcc_pkg::*;

    // shape codes the package does not name
    localparam logic [1:0] SHAPE_NONE  = 2'd2;
    localparam logic [1:0] SHAPE_SPARE = 2'd3;

    // one pixel in Q11.4 and a scale of 1.0 in Q7.8
    localparam int PX  = 16;
    localparam int ONE = 256;

    localparam int RANDOM_PER_PHASE = 230;
    localparam int PHASES           = 8;
    localparam int HOLDOFF_CYCLES   = 240;
    // longest correct quiet stretch is the receiver hold-off; allow far more
    localparam int STUCK_LIMIT      = 4000;

    typedef struct {
        logic                command;
        logic [1:0]          shape;
        logic [FIELD_W-1:0]  pos_x, pos_y, offset_x, offset_y;
        logic [FIELD_W-1:0]  box_width, box_height, scale_x, scale_y;
    } t_request;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               command;
    logic [1:0]         shape;
    logic [FIELD_W-1:0] pos_x, pos_y, offset_x, offset_y;
    logic [FIELD_W-1:0] box_width, box_height, scale_x, scale_y;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         outcome;

    int                 errors;
    int                 pending;

    // idle and stall rates in percent, set per phase by the stimulus process
    int                 tx_idle_pct;
    int                 rx_stall_pct;
    bit                 holdoff_req;

    sprite_box_circle_collision uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_command    (command),
        .i_shape      (shape),
        .i_pos_x      (pos_x),
        .i_pos_y      (pos_y),
        .i_offset_x   (offset_x),
        .i_offset_y   (offset_y),
        .i_box_width  (box_width),
        .i_box_height (box_height),
        .i_scale_x    (scale_x),
        .i_scale_y    (scale_y),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_outcome    (outcome)
    );

    sbcc_outcome_checker outcome_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_command    (command),
        .i_shape      (shape),
        .i_pos_x      (pos_x),
        .i_pos_y      (pos_y),
        .i_offset_x   (offset_x),
        .i_offset_y   (offset_y),
        .i_box_width  (box_width),
        .i_box_height (box_height),
        .i_scale_x    (scale_x),
        .i_scale_y    (scale_y),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_outcome    (outcome),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver: stall at the phase rate; on request, hold off for a long
    // stretch so the block fills up and backs up the request channel.
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (holdoff_req) begin
                out_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge clk);
                holdoff_req = 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves anything.
    initial begin
        int stuck_cycles;
        stuck_cycles = 0;
        while (stuck_cycles < STUCK_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stuck_cycles = 0;
            else
                stuck_cycles = stuck_cycles + 1;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic t_request sprite(logic cmd, logic [1:0] shp,
                                        int px, int py, int ox, int oy,
                                        int w, int h, int sx, int sy);
        t_request r;
        r.command    = cmd;
        r.shape      = shp;
        r.pos_x      = FIELD_W'(px);
        r.pos_y      = FIELD_W'(py);
        r.offset_x   = FIELD_W'(ox);
        r.offset_y   = FIELD_W'(oy);
        r.box_width  = FIELD_W'(w);
        r.box_height = FIELD_W'(h);
        r.scale_x    = FIELD_W'(sx);
        r.scale_y    = FIELD_W'(sy);
        return r;
    endfunction

    // uniform value in [-span, span], truncated to a field
    function automatic logic [FIELD_W-1:0] near(int span);
        return FIELD_W'(int'($urandom_range(2 * span)) - span);
    endfunction

    // Mostly sprites within a few pixels of the origin, so hits and misses
    // both occur; the rest take arbitrary bits in every field.
    function automatic t_request random_request();
        t_request r;
        int       pick;
        r.command = ($urandom_range(99) < 22) ? CMD_LOAD : CMD_TEST;
        pick = $urandom_range(99);
        if (pick < 45)
            r.shape = SHAPE_RECT;
        else if (pick < 88)
            r.shape = SHAPE_ROUND;
        else
            r.shape = ($urandom_range(1) == 0) ? SHAPE_NONE : SHAPE_SPARE;
        if ($urandom_range(99) < 85) begin
            r.pos_x      = near(200);
            r.pos_y      = near(200);
            r.offset_x   = near(32);
            r.offset_y   = near(32);
            r.box_width  = near(128);
            r.box_height = near(128);
            r.scale_x    = near(512);
            r.scale_y    = near(512);
        end else begin
            r.pos_x      = FIELD_W'($urandom);
            r.pos_y      = FIELD_W'($urandom);
            r.offset_x   = FIELD_W'($urandom);
            r.offset_y   = FIELD_W'($urandom);
            r.box_width  = FIELD_W'($urandom);
            r.box_height = FIELD_W'($urandom);
            r.scale_x    = FIELD_W'($urandom);
            r.scale_y    = FIELD_W'($urandom);
        end
        // make most circles true circles so they reach the distance test
        if (r.shape == SHAPE_ROUND && $urandom_range(99) < 80) begin
            r.box_height = r.box_width;
            r.scale_y    = r.scale_x;
        end
        return r;
    endfunction

    // Offer one request, idling first at the phase rate; return at the
    // falling edge after it was accepted.
    task automatic put_request(input t_request r);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        command    <= r.command;
        shape      <= r.shape;
        pos_x      <= r.pos_x;
        pos_y      <= r.pos_y;
        offset_x   <= r.offset_x;
        offset_y   <= r.offset_y;
        box_width  <= r.box_width;
        box_height <= r.box_height;
        scale_x    <= r.scale_x;
        scale_y    <= r.scale_y;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid and hold the sender until every outcome has come back.
    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    initial begin
        t_request directed[$];

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        command      = CMD_LOAD;
        shape        = SHAPE_RECT;
        pos_x        = '0;
        pos_y        = '0;
        offset_x     = '0;
        offset_y     = '0;
        box_width    = '0;
        box_height   = '0;
        scale_x      = '0;
        scale_y      = '0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        holdoff_req  = 1'b0;

        // Reference after reset is a zero-size box at the origin.
        directed.push_back(sprite(CMD_TEST, SHAPE_RECT, 0, 0, 0, 0, PX, PX, ONE, ONE));
        // 2x2 px box at the origin as reference
        directed.push_back(sprite(CMD_LOAD, SHAPE_RECT, 0, 0, 0, 0, 2*PX, 2*PX, ONE, ONE));
        // edges touch exactly in x, then one LSB apart, then touch in y
        directed.push_back(sprite(CMD_TEST, SHAPE_RECT, 2*PX, 0, 0, 0, 2*PX, 2*PX, ONE, ONE));
        directed.push_back(sprite(CMD_TEST, SHAPE_RECT, 2*PX+1, 0, 0, 0, 2*PX, 2*PX, ONE, ONE));
        directed.push_back(sprite(CMD_TEST, SHAPE_RECT, 0, -2*PX, 0, 0, 2*PX, 2*PX, ONE, ONE));
        // circle at exactly its radius from the box misses, one LSB closer hits
        directed.push_back(sprite(CMD_TEST, SHAPE_ROUND, 2*PX, 0, 0, 0, 2*PX, 2*PX, ONE, ONE));
        directed.push_back(sprite(CMD_TEST, SHAPE_ROUND, 2*PX-1, 0, 0, 0, 2*PX, 2*PX, ONE, ONE));
        // hits only when the whole offset moves the circle centre
        directed.push_back(sprite(CMD_TEST, SHAPE_ROUND, 3*PX, 0, -PX-1, 0,
                                  2*PX, 2*PX, ONE, ONE));
        // not a true circle: unequal size, then scales equal only in magnitude
        directed.push_back(sprite(CMD_TEST, SHAPE_ROUND, 0, 0, 0, 0, 2*PX, 3*PX, ONE, ONE));
        directed.push_back(sprite(CMD_TEST, SHAPE_ROUND, 0, 0, 0, 0, 2*PX, 2*PX, ONE, -ONE));
        // negative size and scale count by magnitude
        directed.push_back(sprite(CMD_TEST, SHAPE_ROUND, PX, PX, 0, 0,
                                  -2*PX, -2*PX, -ONE, -ONE));
        // shape none and the spare code never collide
        directed.push_back(sprite(CMD_TEST, SHAPE_NONE, 0, 0, 0, 0, 2*PX, 2*PX, ONE, ONE));
        directed.push_back(sprite(CMD_TEST, SHAPE_SPARE, 0, 0, 0, 0, 2*PX, 2*PX, ONE, ONE));
        // circle as reference: box on the test side
        directed.push_back(sprite(CMD_LOAD, SHAPE_ROUND, 0, 0, 0, 0, 2*PX, 2*PX, ONE, ONE));
        directed.push_back(sprite(CMD_TEST, SHAPE_RECT, 2*PX-1, 0, 0, 0, 2*PX, 2*PX, ONE, ONE));
        directed.push_back(sprite(CMD_TEST, SHAPE_RECT, 2*PX, 0, 0, 0, 2*PX, 2*PX, ONE, ONE));
        // circle against circle is unsupported
        directed.push_back(sprite(CMD_TEST, SHAPE_ROUND, 0, 0, 0, 0, 2*PX, 2*PX, ONE, ONE));
        // stretched circle as reference
        directed.push_back(sprite(CMD_LOAD, SHAPE_ROUND, 0, 0, 0, 0, 2*PX, PX, ONE, ONE));
        directed.push_back(sprite(CMD_TEST, SHAPE_RECT, 0, 0, 0, 0, 2*PX, 2*PX, ONE, ONE));
        // shape none as reference
        directed.push_back(sprite(CMD_LOAD, SHAPE_NONE, 0, 0, 0, 0, 2*PX, 2*PX, ONE, ONE));
        directed.push_back(sprite(CMD_TEST, SHAPE_RECT, 0, 0, 0, 0, 2*PX, 2*PX, ONE, ONE));
        // field extremes: most negative everywhere against most positive
        directed.push_back(sprite(CMD_LOAD, SHAPE_RECT, -32768, -32768, -32768, -32768,
                                  -32768, -32768, -32768, -32768));
        directed.push_back(sprite(CMD_TEST, SHAPE_RECT, 32767, 32767, 32767, 32767,
                                  32767, 32767, 32767, 32767));
        directed.push_back(sprite(CMD_TEST, SHAPE_ROUND, -32768, -32768, -32768, -32768,
                                  -32768, -32768, -32768, -32768));
        directed.push_back(sprite(CMD_TEST, SHAPE_RECT, 32767, -32768, 0, 32767,
                                  0, 0, 0, 0));

        // hold reset, then release it at a falling edge
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i]) put_request(directed[i]);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 61; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 61; end
                default: begin tx_idle_pct = 12; rx_stall_pct = 12; end
            endcase
            // keep offering at full rate while the receiver holds off
            if (phase == 0) holdoff_req = 1'b1;
            repeat (RANDOM_PER_PHASE) put_request(random_request());
            // pause the sender until every outcome is back
            drain();
        end

        // let the block settle past its longest test
        repeat (16) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
